// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/hctbp_pkg.sv =====
package hctbp_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_CODE_LEN  = 32;
  localparam int WORD_W        = 32;
  localparam int LEN_LIMIT     = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam int BYTE_BITS     = 8;
  localparam int ADDR_W        = 8;
  localparam int LEN_W         = 6;
  localparam int PEND_W        = BYTE_BITS - 1;
  localparam int ACC_W         = PEND_W + WORD_W;
  localparam int MAX_BYTES     = WORD_W / BYTE_BITS;
  localparam int CNT_W         = 3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_NO_CODE = 1'b1
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } tbl_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              loaded;
  } tbl_rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } emit_load_t;

endpackage

// ===== src/hctbp_table.sv =====
module hctbp_table (
  input  logic                clk,
  input  logic                rst,
  input  hctbp_pkg::tbl_req_t req,
  output hctbp_pkg::tbl_rsp_t rsp
);

  logic [hctbp_pkg::WORD_W+hctbp_pkg::LEN_W-1:0] mem [hctbp_pkg::ALPHABET_SIZE];
  logic [hctbp_pkg::ALPHABET_SIZE-1:0]           loaded;
  logic [hctbp_pkg::WORD_W+hctbp_pkg::LEN_W-1:0] rd_data;
  logic                                          rd_loaded;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= {req.word, req.len};
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      rd_loaded <= 1'b0;
    end else begin
      if (req.wr_en) begin
        loaded[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_loaded <= loaded[req.addr];
      end
    end
  end

  assign rsp.word   = rd_data[hctbp_pkg::WORD_W+hctbp_pkg::LEN_W-1:hctbp_pkg::LEN_W];
  assign rsp.len    = rd_data[hctbp_pkg::LEN_W-1:0];
  assign rsp.loaded = rd_loaded;

endmodule

// ===== src/hctbp_packer.sv =====
module hctbp_packer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           kind,
  input  logic [hctbp_pkg::ADDR_W-1:0]         symbol,
  input  logic [hctbp_pkg::WORD_W-1:0]         code_bits,
  input  logic [hctbp_pkg::LEN_W-1:0]          code_len,
  output hctbp_pkg::tbl_req_t                  tbl_req,
  input  hctbp_pkg::tbl_rsp_t                  tbl_rsp,
  input  logic                                 em_free,
  output logic                                 em_load_en,
  output hctbp_pkg::emit_load_t                em_load
);

  logic                             accept;
  logic                             in_range;
  logic [hctbp_pkg::LEN_W-1:0]      sat_len;
  logic                             is_load;
  logic                             is_data;
  logic                             is_flush;

  logic                             s1_valid;
  logic                             s1_flush;
  logic                             s1_range;
  logic [hctbp_pkg::PEND_W-1:0]     pending_bits;
  logic [hctbp_pkg::CNT_W-1:0]      pending_count;

  logic                             err;
  logic [hctbp_pkg::ACC_W-1:0]      acc;
  logic [hctbp_pkg::LEN_W-1:0]      n;
  logic [hctbp_pkg::CNT_W-1:0]      nbytes;
  logic [hctbp_pkg::CNT_W-1:0]      nrem;
  logic [hctbp_pkg::WORD_W-1:0]     win;
  logic [hctbp_pkg::WORD_W-1:0]     aligned;
  logic [hctbp_pkg::PEND_W-1:0]     pending_bits_next;
  logic [hctbp_pkg::BYTE_BITS-1:0]  flush_byte;
  logic                             needs_out;
  logic                             go;

  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, symbol} < 9'(hctbp_pkg::ALPHABET_SIZE);
  assign sat_len  = (code_len > hctbp_pkg::LEN_W'(hctbp_pkg::LEN_LIMIT)) ?
                    hctbp_pkg::LEN_W'(hctbp_pkg::LEN_LIMIT) : code_len;

  always_comb begin
    is_load  = 1'b0;
    is_data  = 1'b0;
    is_flush = 1'b0;
    case (hctbp_pkg::kind_t'(kind))
      hctbp_pkg::KIND_LOAD:  is_load  = 1'b1;
      hctbp_pkg::KIND_DATA:  is_data  = 1'b1;
      hctbp_pkg::KIND_FLUSH: is_flush = 1'b1;
      default: ;
    endcase
  end

  // Store the code already masked to its length.
  always_comb begin
    tbl_req.wr_en = accept && is_load && in_range;
    tbl_req.rd_en = accept && is_data;
    tbl_req.addr  = symbol;
    tbl_req.word  = hctbp_pkg::WORD_W'({1'b0, code_bits} &
                    ~({(hctbp_pkg::WORD_W+1){1'b1}} << sat_len));
    tbl_req.len   = sat_len;
  end

  always_comb begin
    err      = !s1_flush && (!s1_range || !tbl_rsp.loaded);
    acc      = (hctbp_pkg::ACC_W'(pending_bits) << tbl_rsp.len) |
               hctbp_pkg::ACC_W'(tbl_rsp.word);
    n        = hctbp_pkg::LEN_W'(pending_count) + tbl_rsp.len;
    nbytes   = n[hctbp_pkg::LEN_W-1:3];
    nrem     = n[2:0];
    win      = hctbp_pkg::WORD_W'(acc >> nrem);
    // Left-align the completed bytes so the first one sits on top.
    aligned  = win << {hctbp_pkg::CNT_W'(hctbp_pkg::MAX_BYTES) - nbytes, 3'b000};
    pending_bits_next = hctbp_pkg::PEND_W'(acc) & ~({hctbp_pkg::PEND_W{1'b1}} << nrem);
    flush_byte = hctbp_pkg::BYTE_BITS'({pending_bits, 1'b1} << (3'd7 - pending_count));
    needs_out  = s1_flush || err || (nbytes != '0);
    go         = s1_valid && (!needs_out || em_free);
    in_stall   = s1_valid && !go;
    em_load_en = go && needs_out;

    if (s1_flush) begin
      em_load.bytes  = {flush_byte, {(hctbp_pkg::WORD_W-hctbp_pkg::BYTE_BITS){1'b0}}};
      em_load.count  = hctbp_pkg::CNT_W'(1);
      em_load.status = hctbp_pkg::STATUS_OK;
    end else if (err) begin
      em_load.bytes  = '0;
      em_load.count  = hctbp_pkg::CNT_W'(1);
      em_load.status = hctbp_pkg::STATUS_NO_CODE;
    end else begin
      em_load.bytes  = aligned;
      em_load.count  = nbytes;
      em_load.status = hctbp_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (accept) begin
        s1_valid <= is_data || is_flush;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        if (s1_flush) begin
          pending_bits  <= '0;
          pending_count <= '0;
        end else if (!err) begin
          pending_bits  <= pending_bits_next;
          pending_count <= nrem;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= is_flush;
      s1_range <= in_range;
    end
  end

endmodule

// ===== src/hctbp_emitter.sv =====
module hctbp_emitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load_en,
  input  hctbp_pkg::emit_load_t            load,
  output logic                             free,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hctbp_pkg::BYTE_BITS-1:0]  byte_out,
  output logic                             status,
  output logic                             last_of_run
);

  logic [hctbp_pkg::WORD_W-1:0] bytes;
  logic [hctbp_pkg::CNT_W-1:0]  count;
  hctbp_pkg::status_t           stat;
  logic                         fire;

  assign out_valid   = count != '0;
  assign fire        = out_valid && !out_stall;
  assign free        = (count == '0) || ((count == hctbp_pkg::CNT_W'(1)) && !out_stall);
  assign byte_out    = bytes[hctbp_pkg::WORD_W-1 -: hctbp_pkg::BYTE_BITS];
  assign status      = stat;
  assign last_of_run = count == hctbp_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_en) begin
      count <= load.count;
    end else if (fire) begin
      count <= count - hctbp_pkg::CNT_W'(1);
    end
  end

  // Advance one byte per transaction on the result side.
  always_ff @(posedge clk) begin
    if (load_en) begin
      bytes <= load.bytes;
      stat  <= load.status;
    end else if (fire) begin
      bytes <= bytes << hctbp_pkg::BYTE_BITS;
    end
  end

endmodule

// ===== src/huffman_code_table_bit_packer.sv =====
// An accepted input is registered in the table read stage, then loaded into the output
// register once it is free. Throughput: one item per cycle while the output register can
// take it; an item with k output bytes (zero to four) holds the result port until all k go.
// Reset clears the entry-loaded bits and the bit packer at once; code table
// contents stay undefined until loaded, with no clearing pass.
`include "assert_macros.svh"

module huffman_code_table_bit_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic        status,
  output logic        last_of_run
);

  hctbp_pkg::tbl_req_t   tbl_req;
  hctbp_pkg::tbl_rsp_t   tbl_rsp;
  hctbp_pkg::emit_load_t em_load;
  logic                  em_load_en;
  logic                  em_free;

  hctbp_table u_table (
    .clk (clk),
    .rst (rst),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  hctbp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .symbol     (symbol),
    .code_bits  (code_bits),
    .code_len   (code_len),
    .tbl_req    (tbl_req),
    .tbl_rsp    (tbl_rsp),
    .em_free    (em_free),
    .em_load_en (em_load_en),
    .em_load    (em_load)
  );

  hctbp_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .load_en     (em_load_en),
    .load        (em_load),
    .free        (em_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_out    (byte_out),
    .status      (status),
    .last_of_run (last_of_run)
  );

  `ASSERT_IMPLY(a_stall_needs_busy_output, in_stall, out_valid)
  `ASSERT_IMPLY(a_error_is_single, out_valid && status, last_of_run)
  `ASSERT_IMPLY(a_error_byte_zero, out_valid && status, byte_out == 8'h00)
  `ASSERT_NEXT(a_load_never_dropped, em_load_en, out_valid)

endmodule

// ===== tb/huffman_code_table_bit_packer_test.sv =====
module huffman_code_table_bit_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]          value;
    hctbp_pkg::status_t  flag;
    logic                last;
  } coded_byte_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [7:0]  symbol;
  logic [31:0] code_bits;
  logic [5:0]  code_len;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  byte_out;
  logic        status;
  logic        last_of_run;

  // Shadow of the code table and the bit packer
  logic [hctbp_pkg::WORD_W-1:0] code_word [hctbp_pkg::ALPHABET_SIZE];
  logic [hctbp_pkg::LEN_W-1:0]  code_length [hctbp_pkg::ALPHABET_SIZE];
  bit                           entry_known [hctbp_pkg::ALPHABET_SIZE];
  logic [hctbp_pkg::PEND_W-1:0] pend_bits;
  int                           pend_count;

  coded_byte_t awaited_bytes[$];
  logic [7:0]  loaded_syms[$];
  coded_byte_t head;

  int in_idle_pct;
  int out_idle_pct;
  int err_count;
  int bytes_checked;
  int nocode_seen;
  int kind_count [4];

  huffman_code_table_bit_packer DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_len    (code_len),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_out    (byte_out),
    .status      (status),
    .last_of_run (last_of_run)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one accepted transaction to the shadow state and queue the bytes it produces.
  function automatic void encode_item(logic [1:0] k, logic [7:0] sym, logic [31:0] bits,
                                      logic [5:0] len);
    logic [63:0] acc;
    logic [15:0] pad;
    int          clen;
    int          n;
    coded_byte_t cb;
    case (k)
      hctbp_pkg::KIND_LOAD: begin
        code_word[sym]   = bits;
        code_length[sym] = (len > hctbp_pkg::LEN_LIMIT) ?
                           hctbp_pkg::LEN_W'(hctbp_pkg::LEN_LIMIT) : len;
        entry_known[sym] = 1'b1;
      end
      hctbp_pkg::KIND_DATA: begin
        if (!entry_known[sym]) begin
          cb.value = 8'h00;
          cb.flag  = hctbp_pkg::STATUS_NO_CODE;
          cb.last  = 1'b1;
          awaited_bytes.push_back(cb);
        end else begin
          clen = code_length[sym];
          acc  = (64'(pend_bits) << clen) | (64'(code_word[sym]) & ((64'd1 << clen) - 64'd1));
          n    = pend_count + clen;
          while (n >= hctbp_pkg::BYTE_BITS) begin
            n -= hctbp_pkg::BYTE_BITS;
            cb.value = 8'(acc >> n);
            cb.flag  = hctbp_pkg::STATUS_OK;
            cb.last  = (n < hctbp_pkg::BYTE_BITS);
            awaited_bytes.push_back(cb);
          end
          pend_bits  = hctbp_pkg::PEND_W'(acc & ((64'd1 << n) - 64'd1));
          pend_count = n;
        end
      end
      hctbp_pkg::KIND_FLUSH: begin
        // Pad with a one, then zeros, up to the byte boundary
        pad = (16'(pend_bits) << (hctbp_pkg::BYTE_BITS - pend_count)) |
              (16'd1 << (hctbp_pkg::BYTE_BITS - 1 - pend_count));
        cb.value = pad[7:0];
        cb.flag  = hctbp_pkg::STATUS_OK;
        cb.last  = 1'b1;
        awaited_bytes.push_back(cb);
        pend_bits  = '0;
        pend_count = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0d ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_item(logic [1:0] k, logic [7:0] sym, logic [31:0] bits, logic [5:0] len);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    kind      <= k;
    symbol    <= sym;
    code_bits <= bits;
    code_len  <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == hctbp_pkg::KIND_LOAD && !entry_known[sym]) loaded_syms.push_back(sym);
    kind_count[k]++;
    encode_item(k, sym, bits, len);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_bytes.size() == 0) begin
        report_mismatch("byte with none outstanding", byte_out, 0);
      end else begin
        head = awaited_bytes.pop_front();
        if (byte_out !== head.value) report_mismatch("byte_out", byte_out, head.value);
        if (status !== head.flag) report_mismatch("status", status, head.flag);
        if (last_of_run !== head.last) report_mismatch("last_of_run", last_of_run, head.last);
        bytes_checked++;
        if (head.flag == hctbp_pkg::STATUS_NO_CODE) nocode_seen++;
      end
    end
  end

  task automatic test_load_and_encode();
    send_item(hctbp_pkg::KIND_LOAD, 8'h00, 32'h0000_0001, 6'd1);
    send_item(hctbp_pkg::KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_item(hctbp_pkg::KIND_LOAD, 8'h41, 32'h0000_00A5, 6'd8);
    send_item(hctbp_pkg::KIND_DATA, 8'h41, 32'h0, 6'd0);
    send_item(hctbp_pkg::KIND_DATA, 8'hFF, 32'h0, 6'd0);
    send_item(hctbp_pkg::KIND_DATA, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_unloaded_symbol();
    // Packer must keep its pending bit across the error
    send_item(hctbp_pkg::KIND_DATA, 8'h7E, 32'hFFFF_FFFF, 6'd63);
  endtask

  task automatic test_overlong_length();
    send_item(hctbp_pkg::KIND_LOAD, 8'h80, 32'h0000_0001, 6'd63);
    send_item(hctbp_pkg::KIND_DATA, 8'h80, 32'h0, 6'd0);
    send_item(hctbp_pkg::KIND_LOAD, 8'h55, 32'hAAAA_AAAA, 6'd33);
    send_item(hctbp_pkg::KIND_DATA, 8'h55, 32'h0, 6'd0);
  endtask

  task automatic test_zero_length();
    send_item(hctbp_pkg::KIND_LOAD, 8'h10, 32'hDEAD_BEEF, 6'd0);
    send_item(hctbp_pkg::KIND_DATA, 8'h10, 32'h0, 6'd0);
  endtask

  task automatic test_flush_padding();
    send_item(hctbp_pkg::KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(hctbp_pkg::KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_item(hctbp_pkg::KIND_LOAD, 8'h20, 32'h0000_0005, 6'd3);
    send_item(hctbp_pkg::KIND_DATA, 8'h20, 32'h0, 6'd0);
    send_item(hctbp_pkg::KIND_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 8'h41, 32'hFFFF_FFFF, 6'd63);
    send_item(hctbp_pkg::KIND_DATA, 8'h41, 32'h0, 6'd0);
  endtask

  task automatic test_random_stream(int count, int in_pct, int out_pct);
    int         done;
    int         r;
    int         rl;
    logic [5:0] len;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 15 || loaded_syms.size() == 0) begin
        rl = $urandom_range(99);
        if (rl < 5) len = 6'd0;
        else if (rl < 12) len = 6'($urandom_range(63, 33));
        else if (rl < 45) len = 6'($urandom_range(8, 1));
        else len = 6'($urandom_range(32, 1));
        send_item(hctbp_pkg::KIND_LOAD, 8'($urandom_range(255)), $urandom, len);
      end else if (r < 82) begin
        send_item(hctbp_pkg::KIND_DATA, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                  $urandom, 6'($urandom_range(63)));
      end else if (r < 87) begin
        // Any symbol, loaded or not
        send_item(hctbp_pkg::KIND_DATA, 8'($urandom_range(255)), $urandom,
                  6'($urandom_range(63)));
      end else if (r < 96) begin
        send_item(hctbp_pkg::KIND_FLUSH, 8'($urandom_range(255)), $urandom,
                  6'($urandom_range(63)));
      end else begin
        send_item(KIND_UNUSED, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
        done--;
      end
      done++;
    end
  endtask

  initial begin
    for (int i = 0; i < hctbp_pkg::ALPHABET_SIZE; i++) entry_known[i] = 1'b0;
    for (int i = 0; i < 4; i++) kind_count[i] = 0;
    pend_bits     = '0;
    pend_count    = 0;
    err_count     = 0;
    bytes_checked = 0;
    nocode_seen   = 0;
    in_idle_pct   = 0;
    out_idle_pct  = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    kind      = hctbp_pkg::KIND_LOAD;
    symbol    = '0;
    code_bits = '0;
    code_len  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_load_and_encode();
    test_unloaded_symbol();
    test_overlong_length();
    test_zero_length();
    test_flush_padding();
    test_unused_kind();
    test_random_stream(127, 26, 61);
    test_random_stream(127, 61, 26);
    test_random_stream(126, 0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d loads, %0d data bytes, %0d flushes, %0d unused-kind transactions",
             kind_count[hctbp_pkg::KIND_LOAD], kind_count[hctbp_pkg::KIND_DATA],
             kind_count[hctbp_pkg::KIND_FLUSH], kind_count[KIND_UNUSED]);
    $display("Checked %0d output bytes, %0d of them no-code errors, %0d mismatches",
             bytes_checked, nocode_seen, err_count);
    if (err_count == 0 && awaited_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d bytes outstanding", awaited_bytes.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
